// File: hw/rtl/tea_pkg.sv
// Shared types, constants and the round mixing function for the TEA encryptor.
// Used by tea_cell, tea_block_encrypt and tea_checker; depends on nothing else.
package tea_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned KEY_INDEX_W = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KEY_INDEX_W-1:0] key_index_t;

  localparam word_t TEA_DELTA = 32'h9E37_79B9;
  localparam int unsigned SHIFT_LEFT = 4;
  localparam int unsigned SHIFT_RIGHT = 5;

  // Register indexes of the configuration port.
  localparam key_index_t KEY_IDX_0 = 2'd0;
  localparam key_index_t KEY_IDX_1 = 2'd1;
  localparam key_index_t KEY_IDX_2 = 2'd2;
  localparam key_index_t KEY_IDX_3 = 2'd3;

  // One block travelling down the chain of half-round cells.
  typedef struct packed {
    logic  valid;
    word_t left;
    word_t right;
  } stage_t;

  // Feistel function of one half update; the three adds run side by side.
  function automatic word_t mix_half(word_t h, word_t sum, word_t ka, word_t kb);
    word_t a;
    word_t b;
    word_t c;
    a = (h << SHIFT_LEFT) + ka;
    b = h + sum;
    c = (h >> SHIFT_RIGHT) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

// File: hw/rtl/tea_cell.sv
// One half-round cell of the TEA chain: updates either the left or the right half.
// Depends on tea_pkg for the stage type and the mixing function.
module tea_cell #(
  parameter bit             UPDATE_RIGHT = 1'b0,
  parameter logic [31:0]    ROUND_SUM    = 32'h9E37_79B9
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  tea_pkg::word_t  key_a,
  input  tea_pkg::word_t  key_b,
  input  tea_pkg::stage_t prev,
  output tea_pkg::stage_t cur
);

  tea_pkg::word_t left_next;
  tea_pkg::word_t right_next;

  always_comb begin
    left_next  = prev.left;
    right_next = prev.right;
    if (UPDATE_RIGHT) begin
      right_next = prev.right + tea_pkg::mix_half(prev.left, ROUND_SUM, key_a, key_b);
    end else begin
      left_next = prev.left + tea_pkg::mix_half(prev.right, ROUND_SUM, key_a, key_b);
    end
  end

  // Only the valid bit is reset; the data halves simply follow the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (advance) begin
      cur.valid <= prev.valid;
    end
    if (advance) begin
      cur.left  <= left_next;
      cur.right <= right_next;
    end
  end

endmodule

// File: hw/rtl/tea_block_encrypt.sv
// Top level of the TEA block encryptor: key registers, input skid stage and
// a chain of 2*ROUND_COUNT half-round cells. Depends on tea_pkg and tea_cell.
//
// Usage: the 128-bit key is loaded through the write port (cfg_we, cfg_index,
// cfg_data), one 32-bit word per write, while no block is in flight. A
// plaintext block is a transfer on the input channel (in_valid, in_ready,
// plain_left, plain_right); the ciphertext comes back as a transfer on the
// output channel (out_valid, out_ready, cipher_left, cipher_right), one
// result per block and in order.
// Each round is split over two cells, the first updating the left half and
// the second the right half, so one round costs two register stages.
// The chain takes a new block every cycle while the output is not stalled,
// so sustained throughput is one block per clock. When the receiver stalls,
// the whole chain holds its contents. A one-entry skid register in front of
// the chain still takes one more block in that case, and in_ready comes
// straight from that register, never from out_ready. Synchronous reset
// clears the key words to zero and drops every block in flight; the output
// channel is idle right after reset.
module tea_block_encrypt #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  tea_pkg::key_index_t    cfg_index,
  input  tea_pkg::word_t         cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tea_pkg::word_t         plain_left,
  input  tea_pkg::word_t         plain_right,
  output logic                   out_valid,
  input  logic                   out_ready,
  output tea_pkg::word_t         cipher_left,
  output tea_pkg::word_t         cipher_right
);

  localparam int unsigned CELL_COUNT = 2 * ROUND_COUNT;

  // Key registers; the user must write them only while the block is idle, which the block itself does not enforce.
  tea_pkg::word_t key [tea_pkg::KEY_WORDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < tea_pkg::KEY_WORDS; k++) begin
        key[k] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        tea_pkg::KEY_IDX_0: key[0] <= cfg_data;
        tea_pkg::KEY_IDX_1: key[1] <= cfg_data;
        tea_pkg::KEY_IDX_2: key[2] <= cfg_data;
        tea_pkg::KEY_IDX_3: key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The chain moves whenever the output register is free or being emptied.
  tea_pkg::stage_t chain [CELL_COUNT+1];
  logic            advance;

  assign advance   = !chain[CELL_COUNT].valid || out_ready;
  assign out_valid = chain[CELL_COUNT].valid;
  assign cipher_left  = chain[CELL_COUNT].left;
  assign cipher_right = chain[CELL_COUNT].right;

  // Skid register: catches a block that arrives while the chain is stalled.
  logic           skid_valid;
  tea_pkg::word_t skid_left;
  tea_pkg::word_t skid_right;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid && advance) begin
      skid_valid <= 1'b0;
    end else if (!skid_valid && in_valid && !advance) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      skid_left  <= plain_left;
      skid_right <= plain_right;
    end
  end

  // Head of the chain: a held block goes first, otherwise the input is taken
  // directly.
  assign chain[0].valid = skid_valid || in_valid;
  assign chain[0].left  = skid_valid ? skid_left  : plain_left;
  assign chain[0].right = skid_valid ? skid_right : plain_right;

  // Cell 2r updates the left half with key words 0 and 1, cell 2r+1 the right
  // half with key words 2 and 3; both use the round sum delta*(r+1).
  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    localparam int unsigned ROUND = i / 2;
    localparam bit          IS_RIGHT = (i % 2) == 1;
    localparam logic [63:0] SUM_WIDE = 64'(tea_pkg::TEA_DELTA) * 64'(ROUND + 1);
    localparam logic [31:0] SUM = SUM_WIDE[31:0];

    tea_cell #(
      .UPDATE_RIGHT (IS_RIGHT),
      .ROUND_SUM    (SUM)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .key_a   (IS_RIGHT ? key[2] : key[0]),
      .key_b   (IS_RIGHT ? key[3] : key[1]),
      .prev    (chain[i]),
      .cur     (chain[i+1])
    );
  end

endmodule

// File: hw/rtl/tea_checker.sv
// Port-level checker for the TEA encryptor, bound to every tea_block_encrypt.
// Depends on tea_pkg for the word type.
module tea_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input tea_pkg::word_t cipher_left,
  input tea_pkg::word_t cipher_right
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(cipher_left) && $stable(cipher_right))
    else $error("result changed while stalled");

  // The skid register only fills from a real transfer.
  assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("input stalled without a held block");

  // A held block drains as soon as the chain moves.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready && (out_ready || !out_valid) |=> in_ready)
    else $error("skid register did not drain");

  // Nothing comes out in the cycle after reset.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind tea_block_encrypt tea_checker u_tea_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .cipher_left  (cipher_left),
  .cipher_right (cipher_right)
);
